// File: rtl/i2cms_pkg.sv
// Shared types and constants of the I2C master transfer sequencer.
// Used by the front end, the back end and the top level; no dependencies.
package i2cms_pkg;

    // Input item kinds as they arrive on the slave-side tuser field.
    localparam logic [2:0] MODE_START    = 3'd0;
    localparam logic [2:0] MODE_LOAD     = 3'd1;
    localparam logic [2:0] MODE_EVENT    = 3'd2;
    localparam logic [2:0] MODE_BUS_IDLE = 3'd3;
    localparam logic [2:0] MODE_TICK     = 3'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int MAX_RESULTS = 3;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    typedef enum logic [2:0] {
        CMD_START,
        CMD_LOAD,
        CMD_EVENT,
        CMD_BUS_IDLE,
        CMD_TICK
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [6:0]  slave_address;
        logic [5:0]  send_count;
        logic [15:0] recv_count;
        logic [7:0]  data_byte;
        logic        arbitration_lost;
        logic        last_bit_nak;
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SEND,
        PH_RECV_TOP,
        PH_RECV,
        PH_RESTART_PEND,
        PH_STOP_PEND,
        PH_WAIT_RESTART,
        PH_WAIT_STOP
    } t_phase;

    typedef enum logic [2:0] {
        ACT_WRITE,
        ACT_START,
        ACT_STOP,
        ACT_RESTART,
        ACT_ACK_OFF,
        ACT_INIT,
        ACT_RECV,
        ACT_DONE
    } t_action;

    typedef enum logic [1:0] {
        ST_OK,
        ST_ARB_LOST,
        ST_NAK,
        ST_TIMEOUT
    } t_status;

    typedef struct packed {
        t_action     action;
        logic [7:0]  data_out;
        t_status     status;
        logic [16:0] byte_count;
    } t_result;

    typedef enum logic [1:0] {
        BS_WAIT,
        BS_EXEC,
        BS_EMIT
    } t_bstate;

endpackage

// File: rtl/i2cms_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; holds the send bytes of the sequencer.
module i2cms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/i2cms_front.sv
// Front end: accepts input transactions, classifies them by mode and queues them.
// Depends on i2cms_pkg; feeds i2cms_back.
module i2cms_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [39:0]   i_s_tdata,
    input  logic [2:0]    i_s_tuser,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output i2cms_pkg::t_cmd o_cmd
);
    import i2cms_pkg::*;

    t_cmd                r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_AW:0]   r_count, n_count;
    t_cmd                dec;
    logic                known;
    logic                push, pop;

    // Unknown modes are accepted and dropped here, so they never reach the back end.
    always_comb begin
        known = 1'b1;
        dec.kind = CMD_START;
        unique case (i_s_tuser)
            MODE_START:    dec.kind = CMD_START;
            MODE_LOAD:     dec.kind = CMD_LOAD;
            MODE_EVENT:    dec.kind = CMD_EVENT;
            MODE_BUS_IDLE: dec.kind = CMD_BUS_IDLE;
            MODE_TICK:     dec.kind = CMD_TICK;
            default:       known = 1'b0;
        endcase
        dec.slave_address    = i_s_tdata[6:0];
        dec.send_count       = i_s_tdata[12:7];
        dec.recv_count       = i_s_tdata[28:13];
        dec.data_byte        = i_s_tdata[36:29];
        dec.arbitration_lost = i_s_tdata[37];
        dec.last_bit_nak     = i_s_tdata[38];
    end

    assign o_s_tready  = (r_count != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign push        = i_s_tvalid && o_s_tready && known;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= dec;
        end
    end

endmodule

// File: rtl/i2cms_back.sv
// Back end: carries out queued commands against the transfer state and emits results.
// Depends on i2cms_pkg and i2cms_ram (send byte buffer).
module i2cms_back #(
    parameter int SEND_DEPTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [15:0]     i_cfg_wdata,
    input  logic            i_cmd_valid,
    output logic            o_cmd_ready,
    input  i2cms_pkg::t_cmd i_cmd,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output i2cms_pkg::t_result o_res,
    output logic            o_last
);
    import i2cms_pkg::*;

    localparam int AW     = (SEND_DEPTH > 1) ? $clog2(SEND_DEPTH) : 1;
    localparam int LPW    = $clog2(SEND_DEPTH + 1);
    localparam int SR_CAP = (SEND_DEPTH < 63) ? SEND_DEPTH : 63;

    t_bstate      r_bstate, n_bstate;
    t_cmd         r_cmd, n_cmd;
    t_phase       r_phase, n_phase;
    logic [LPW-1:0] r_load_ptr, n_load_ptr;
    logic [AW-1:0]  r_send_ptr, n_send_ptr;
    logic [5:0]   r_send_rem, n_send_rem;
    logic [15:0]  r_recv_rem, n_recv_rem;
    logic [6:0]   r_target, n_target;
    logic [16:0]  r_xfer, n_xfer;
    logic [15:0]  r_idle_ticks, n_idle_ticks;
    logic [15:0]  r_timeout;
    t_result      r_res [MAX_RESULTS];
    t_result      n_res [MAX_RESULTS];
    logic [1:0]   r_cnt, n_cnt;
    logic [1:0]   r_idx, n_idx;

    logic         ram_we;
    logic [7:0]   ram_rdata;

    i2cms_ram #(
        .WIDTH (8),
        .DEPTH (SEND_DEPTH)
    ) u_send_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_load_ptr[AW-1:0]),
        .i_wdata (r_cmd.data_byte),
        .i_raddr (r_send_ptr),
        .o_rdata (ram_rdata)
    );

    assign o_cmd_ready = (r_bstate == BS_WAIT);
    assign o_m_tvalid  = (r_bstate == BS_EMIT);
    assign o_res       = r_res[r_idx];
    assign o_last      = (r_idx == r_cnt - 2'd1);

    always_comb begin
        logic        do_abort;
        logic        do_issue;
        t_status     abort_st;
        logic [1:0]  k;
        logic [15:0] limit;
        logic [7:0]  addr_byte;

        n_bstate     = r_bstate;
        n_cmd        = r_cmd;
        n_phase      = r_phase;
        n_load_ptr   = r_load_ptr;
        n_send_ptr   = r_send_ptr;
        n_send_rem   = r_send_rem;
        n_recv_rem   = r_recv_rem;
        n_target     = r_target;
        n_xfer       = r_xfer;
        n_idle_ticks = r_idle_ticks;
        n_res        = r_res;
        n_cnt        = r_cnt;
        n_idx        = r_idx;
        ram_we       = 1'b0;
        do_abort     = 1'b0;
        do_issue     = 1'b0;
        abort_st     = ST_OK;
        k            = 2'd0;
        limit        = (r_timeout == 16'd0) ? 16'd1 : r_timeout;
        addr_byte    = '0;

        unique case (r_bstate)
            BS_WAIT: begin
                if (i_cmd_valid) begin
                    n_cmd    = i_cmd;
                    n_bstate = BS_EXEC;
                end
            end

            BS_EXEC: begin
                for (int i = 0; i < MAX_RESULTS; i++) begin
                    n_res[i] = '{action: ACT_WRITE, data_out: 8'd0, status: ST_OK,
                                 byte_count: 17'd0};
                end

                case (r_cmd.kind)
                    CMD_START: begin
                        if (r_phase == PH_IDLE) begin
                            n_target     = r_cmd.slave_address;
                            n_send_rem   = (r_cmd.send_count > 6'(SR_CAP)) ?
                                           6'(SR_CAP) : r_cmd.send_count;
                            n_recv_rem   = r_cmd.recv_count;
                            n_send_ptr   = '0;
                            n_load_ptr   = '0;
                            n_xfer       = '0;
                            n_idle_ticks = '0;
                            if (n_send_rem == 6'd0 && n_recv_rem == 16'd0) begin
                                n_res[k].action = ACT_DONE;
                                k = k + 2'd1;
                            end else begin
                                do_issue = 1'b1;
                            end
                        end
                    end

                    CMD_LOAD: begin
                        if (r_phase == PH_IDLE && r_load_ptr < LPW'(SEND_DEPTH)) begin
                            ram_we     = 1'b1;
                            n_load_ptr = r_load_ptr + 1'b1;
                        end
                    end

                    CMD_EVENT: begin
                        if (r_phase != PH_IDLE) begin
                            if (r_cmd.arbitration_lost) begin
                                do_abort = 1'b1;
                                abort_st = ST_ARB_LOST;
                            end else begin
                                n_idle_ticks = '0;
                                unique case (r_phase) inside
                                    PH_SEND: begin
                                        if (r_cmd.last_bit_nak) begin
                                            do_abort = 1'b1;
                                            abort_st = ST_NAK;
                                        end else begin
                                            n_res[k].action   = ACT_WRITE;
                                            n_res[k].data_out = ram_rdata;
                                            k = k + 2'd1;
                                            n_send_ptr = r_send_ptr + 1'b1;
                                            n_xfer     = r_xfer + 17'd1;
                                            if (r_send_rem != 6'd0) begin
                                                n_send_rem = r_send_rem - 6'd1;
                                            end
                                            if (n_send_rem == 6'd0) begin
                                                n_phase = (r_recv_rem != 16'd0) ?
                                                          PH_RESTART_PEND : PH_STOP_PEND;
                                            end
                                        end
                                    end
                                    PH_RECV_TOP: begin
                                        // The first read event is a dummy read.
                                        if (r_recv_rem == 16'd1) begin
                                            n_res[k].action = ACT_ACK_OFF;
                                            k = k + 2'd1;
                                        end
                                        n_phase = PH_RECV;
                                    end
                                    PH_RECV: begin
                                        if (r_recv_rem == 16'd1) begin
                                            n_res[k].action = ACT_ACK_OFF;
                                            k = k + 2'd1;
                                        end
                                        n_res[k].action   = ACT_RECV;
                                        n_res[k].data_out = r_cmd.data_byte;
                                        k = k + 2'd1;
                                        n_xfer = r_xfer + 17'd1;
                                        if (r_recv_rem != 16'd0) begin
                                            n_recv_rem = r_recv_rem - 16'd1;
                                        end
                                        if (n_recv_rem == 16'd0) begin
                                            n_phase = PH_STOP_PEND;
                                        end
                                    end
                                    PH_RESTART_PEND, PH_WAIT_RESTART: begin
                                        n_res[k].action = ACT_RESTART;
                                        k = k + 2'd1;
                                        n_phase = PH_WAIT_RESTART;
                                    end
                                    default: begin
                                        n_res[k].action = ACT_STOP;
                                        k = k + 2'd1;
                                        n_phase = PH_WAIT_STOP;
                                    end
                                endcase
                            end
                        end
                    end

                    CMD_BUS_IDLE: begin
                        if (r_phase == PH_WAIT_RESTART) begin
                            n_idle_ticks = '0;
                            do_issue     = 1'b1;
                        end else if (r_phase == PH_WAIT_STOP) begin
                            n_res[k].action     = ACT_DONE;
                            n_res[k].byte_count = r_xfer;
                            k = k + 2'd1;
                            n_phase = PH_IDLE;
                        end
                    end

                    CMD_TICK: begin
                        if (r_phase != PH_IDLE) begin
                            if (r_idle_ticks != 16'hffff) begin
                                n_idle_ticks = r_idle_ticks + 16'd1;
                            end
                            if (n_idle_ticks >= limit) begin
                                do_abort = 1'b1;
                                abort_st = ST_TIMEOUT;
                            end
                        end
                    end

                    default: begin
                    end
                endcase

                // An abort issues a stop and reports the bytes moved so far.
                if (do_abort) begin
                    n_res[k].action = ACT_STOP;
                    k = k + 2'd1;
                    n_res[k].action     = ACT_DONE;
                    n_res[k].status     = abort_st;
                    n_res[k].byte_count = r_xfer;
                    k = k + 2'd1;
                    n_phase = PH_IDLE;
                end

                // Address phase: write bit while bytes remain to send, read bit otherwise.
                if (do_issue) begin
                    addr_byte = {n_target, 1'b0};
                    if (n_send_rem != 6'd0) begin
                        n_phase = PH_SEND;
                    end else begin
                        addr_byte[0] = 1'b1;
                        n_phase = PH_RECV_TOP;
                    end
                    n_res[k].action = ACT_INIT;
                    k = k + 2'd1;
                    n_res[k].action   = ACT_WRITE;
                    n_res[k].data_out = addr_byte;
                    k = k + 2'd1;
                    n_res[k].action = ACT_START;
                    k = k + 2'd1;
                end

                n_cnt    = k;
                n_idx    = 2'd0;
                n_bstate = (k != 2'd0) ? BS_EMIT : BS_WAIT;
            end

            BS_EMIT: begin
                if (i_m_tready) begin
                    if (o_last) begin
                        n_bstate = BS_WAIT;
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end
            end

            default: n_bstate = BS_WAIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bstate     <= BS_WAIT;
            r_phase      <= PH_IDLE;
            r_load_ptr   <= '0;
            r_send_ptr   <= '0;
            r_send_rem   <= '0;
            r_recv_rem   <= '0;
            r_target     <= '0;
            r_xfer       <= '0;
            r_idle_ticks <= '0;
            r_timeout    <= TIMEOUT_RESET;
            r_cnt        <= '0;
            r_idx        <= '0;
        end else begin
            r_bstate     <= n_bstate;
            r_phase      <= n_phase;
            r_load_ptr   <= n_load_ptr;
            r_send_ptr   <= n_send_ptr;
            r_send_rem   <= n_send_rem;
            r_recv_rem   <= n_recv_rem;
            r_target     <= n_target;
            r_xfer       <= n_xfer;
            r_idle_ticks <= n_idle_ticks;
            r_cnt        <= n_cnt;
            r_idx        <= n_idx;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_res <= n_res;
    end

endmodule

// File: rtl/i2c_master_transfer_sequencer_unit.sv
// I2C master transfer sequencer (write, restart, read) over a byte-level controller:
// commands come in on the slave-side stream, controller actions leave on the
// master-side stream. The front end accepts one input transaction per cycle into a
// four-entry queue while it is not full, so the input keeps flowing while results
// wait on the output. The back end registers a queued command, with the send byte
// RAM read registered meanwhile, executes it against the transfer state, and then
// emits its results one per cycle while the receiver is ready. It takes no new
// command until the last result of the previous one has been accepted.
// A start with both counts zero ends at once with a done result; unknown modes are
// accepted and dropped. The timeout register is written through i_cfg_we/i_cfg_wdata
// and should only be changed while no transaction is in flight. There is no clearing
// pass after reset; send bytes that were never loaded read back as whatever the
// buffer holds.
// Depends on i2cms_pkg, i2cms_front, i2cms_back and i2cms_ram.
module i2c_master_transfer_sequencer_unit #(
    parameter int SEND_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: timeout_ticks.
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    // Slave side.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: slave_address[6:0], send_count[12:7], recv_count[28:13],
    //        data_byte[36:29], arbitration_lost[37], last_bit_nak[38], zero[39].
    input  logic [39:0] i_s_tdata,
    // tuser: mode[2:0].
    input  logic [2:0]  i_s_tuser,
    // Master side.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: data_out[7:0], status[9:8], byte_count[26:10], zero[31:27].
    output logic [31:0] o_m_tdata,
    // tuser: action[2:0].
    output logic [2:0]  o_m_tuser,
    output logic        o_m_tlast
);
    import i2cms_pkg::*;

    logic    cmd_valid;
    logic    cmd_ready;
    t_cmd    cmd;
    t_result res;
    logic    res_last;

    i2cms_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    i2cms_back #(
        .SEND_DEPTH (SEND_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_res       (res),
        .o_last      (res_last)
    );

    // Pack the result: the action travels as tuser, everything else in tdata.
    assign o_m_tuser = res.action;
    assign o_m_tdata = {5'd0, res.byte_count, res.status, res.data_out};
    assign o_m_tlast = res_last;

endmodule

// File: tb/i2c_master_transfer_sequencer_unit_tb.sv
// Self-checking testbench for the I2C master transfer sequencer unit.
// It predicts every controller action in a behavioral model of its own and checks the
// output stream against it. It depends on i2cms_pkg and the RTL of the unit.
module i2c_master_transfer_sequencer_unit_tb;
    import i2cms_pkg::*;

    localparam int         SEND_DEPTH    = 32;
    // Enough cycles for commands that make no result to drain out of the four-entry
    // queue after the last expected result has left.
    localparam int         SETTLE_CYCLES = 32;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         CHUNK_ITEMS   = 8;
    localparam logic [2:0] MODE_RSVD_LO  = 3'd5;
    localparam logic [2:0] MODE_RSVD_HI  = 3'd7;

    // One command as the testbench builds it, before packing into tdata and tuser.
    typedef struct packed {
        logic [2:0]  mode;
        logic [6:0]  addr;
        logic [5:0]  send_count;
        logic [15:0] recv_count;
        logic [7:0]  data;
        logic        arb_lost;
        logic        nak;
    } t_stim_cmd;

    // One controller action as it should leave the unit.
    typedef struct packed {
        t_action     action;
        logic [7:0]  data;
        t_status     status;
        logic [16:0] count;
        logic        last;
    } t_expect_op;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;
    logic [2:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        o_m_tlast;

    i2c_master_transfer_sequencer_unit #(
        .SEND_DEPTH(SEND_DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Shared controls of the two stream sides. When no_gaps is set neither side idles;
    // sink_hold makes the receiver refuse results for that many cycles.
    bit no_gaps   = 1'b0;
    int sink_hold = 0;

    // Run bookkeeping.
    int errors       = 0;
    int results_seen = 0;
    int items_sent   = 0;
    int items_live   = 0;
    int cfg_writes   = 0;

    // Predicted state of the sequencer, kept in step with every accepted command.
    t_phase      seq_phase;
    logic [7:0]  tx_bytes [SEND_DEPTH];
    int unsigned tx_fill;
    int unsigned tx_next;
    int unsigned tx_left;
    int unsigned tx_loaded;    // entries of the send buffer written at least once
    logic [15:0] rx_left;
    logic [7:0]  addr_byte;
    logic [16:0] moved;
    logic [15:0] stall_ticks;
    logic [15:0] timeout_limit;

    t_expect_op  pending_ops[$];    // actions still to come out, oldest first
    t_expect_op  fresh_ops[$];      // actions of the command being predicted

    // ------------------------------------------------------------------------
    // Behavioral prediction
    // ------------------------------------------------------------------------

    task automatic emit_op(input t_action act, input logic [7:0] d, input t_status st,
                           input logic [16:0] cnt);
        fresh_ops.push_back('{act, d, st, cnt, 1'b0});
    endtask

    // Any abort closes the bus with a stop and reports the bytes moved so far.
    task automatic abort_transfer(input t_status st);
        emit_op(ACT_STOP, 8'h00, ST_OK, 17'd0);
        emit_op(ACT_DONE, 8'h00, st, moved);
        seq_phase = PH_IDLE;
    endtask

    // Address phase: init with ACK enabled, then the address byte, then a start.
    // The read bit is set only when nothing is left to send.
    task automatic address_phase();
        emit_op(ACT_INIT, 8'h00, ST_OK, 17'd0);
        if (tx_left > 0) begin
            seq_phase = PH_SEND;
            emit_op(ACT_WRITE, addr_byte, ST_OK, 17'd0);
        end else begin
            seq_phase = PH_RECV_TOP;
            emit_op(ACT_WRITE, addr_byte | 8'h01, ST_OK, 17'd0);
        end
        emit_op(ACT_START, 8'h00, ST_OK, 17'd0);
    endtask

    task automatic controller_event(input t_stim_cmd c);
        if (c.arb_lost) begin
            abort_transfer(ST_ARB_LOST);
        end else begin
            stall_ticks = 16'd0;
            case (seq_phase)
                PH_SEND: begin
                    // A NAK only matters while bytes are being written.
                    if (c.nak) begin
                        abort_transfer(ST_NAK);
                    end else begin
                        emit_op(ACT_WRITE, tx_bytes[tx_next], ST_OK, 17'd0);
                        tx_next++;
                        moved++;
                        if (tx_left > 0) tx_left--;
                        if (tx_left == 0) begin
                            seq_phase = (rx_left != 0) ? PH_RESTART_PEND : PH_STOP_PEND;
                        end
                    end
                end
                PH_RECV_TOP: begin
                    // The first read event is a dummy read; no byte is handed out.
                    if (rx_left == 16'd1) emit_op(ACT_ACK_OFF, 8'h00, ST_OK, 17'd0);
                    seq_phase = PH_RECV;
                end
                PH_RECV: begin
                    if (rx_left == 16'd1) emit_op(ACT_ACK_OFF, 8'h00, ST_OK, 17'd0);
                    emit_op(ACT_RECV, c.data, ST_OK, 17'd0);
                    moved++;
                    if (rx_left != 0) rx_left--;
                    if (rx_left == 0) seq_phase = PH_STOP_PEND;
                end
                PH_RESTART_PEND, PH_WAIT_RESTART: begin
                    emit_op(ACT_RESTART, 8'h00, ST_OK, 17'd0);
                    seq_phase = PH_WAIT_RESTART;
                end
                default: begin
                    emit_op(ACT_STOP, 8'h00, ST_OK, 17'd0);
                    seq_phase = PH_WAIT_STOP;
                end
            endcase
        end
    endtask

    // Applies one accepted command to the predicted state and queues the actions it
    // causes. acted tells whether the command did anything at all.
    task automatic advance_sequencer(input t_stim_cmd c, output bit acted);
        logic [15:0] lim;
        t_expect_op  op;
        fresh_ops.delete();
        acted = 1'b0;
        case (c.mode)
            MODE_START: begin
                if (seq_phase == PH_IDLE) begin
                    acted       = 1'b1;
                    addr_byte   = {c.addr, 1'b0};
                    tx_left     = (c.send_count > SEND_DEPTH) ? SEND_DEPTH : c.send_count;
                    rx_left     = c.recv_count;
                    tx_next     = 0;
                    tx_fill     = 0;
                    moved       = 17'd0;
                    stall_ticks = 16'd0;
                    if (tx_left == 0 && rx_left == 0) begin
                        emit_op(ACT_DONE, 8'h00, ST_OK, 17'd0);
                    end else begin
                        address_phase();
                    end
                end
            end
            MODE_LOAD: begin
                if (seq_phase == PH_IDLE && tx_fill < SEND_DEPTH) begin
                    acted             = 1'b1;
                    tx_bytes[tx_fill] = c.data;
                    tx_fill++;
                    if (tx_fill > tx_loaded) tx_loaded = tx_fill;
                end
            end
            MODE_EVENT: begin
                if (seq_phase != PH_IDLE) begin
                    acted = 1'b1;
                    controller_event(c);
                end
            end
            MODE_BUS_IDLE: begin
                if (seq_phase == PH_WAIT_RESTART) begin
                    acted       = 1'b1;
                    stall_ticks = 16'd0;
                    address_phase();
                end else if (seq_phase == PH_WAIT_STOP) begin
                    acted = 1'b1;
                    emit_op(ACT_DONE, 8'h00, ST_OK, moved);
                    seq_phase = PH_IDLE;
                end
            end
            MODE_TICK: begin
                if (seq_phase != PH_IDLE) begin
                    acted = 1'b1;
                    // A timeout setting of zero behaves like one tick.
                    lim = (timeout_limit == 16'd0) ? 16'd1 : timeout_limit;
                    if (stall_ticks != 16'hffff) stall_ticks++;
                    if (stall_ticks >= lim) abort_transfer(ST_TIMEOUT);
                end
            end
            default: ;
        endcase
        if (fresh_ops.size() != 0) begin
            op      = fresh_ops.pop_back();
            op.last = 1'b1;
            fresh_ops.push_back(op);
        end
        foreach (fresh_ops[i]) pending_ops.push_back(fresh_ops[i]);
    endtask

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offers one command after a random gap and predicts it once the transaction
    // has completed. All inputs change on the falling edge.
    task automatic offer_cmd(input t_stim_cmd c);
        int gap;
        bit acted;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= c.mode;
        i_s_tdata  <= {1'b0, c.nak, c.arb_lost, c.data, c.recv_count, c.send_count, c.addr};
        do @(posedge i_clk); while (!o_s_tready);
        advance_sequencer(c, acted);
        items_sent++;
        if (acted) items_live++;
    endtask

    // A command of the given kind with every other field random, so that fields the
    // kind does not use still toggle on the bus.
    function automatic t_stim_cmd fresh_cmd(input logic [2:0] m);
        t_stim_cmd c;
        c.mode       = m;
        c.addr       = 7'($urandom_range(0, 127));
        c.send_count = 6'($urandom_range(0, 63));
        c.recv_count = 16'($urandom_range(0, 65535));
        c.data       = 8'($urandom_range(0, 255));
        c.arb_lost   = 1'($urandom_range(0, 1));
        c.nak        = 1'($urandom_range(0, 1));
        return c;
    endfunction

    task automatic offer_mode(input logic [2:0] m);
        offer_cmd(fresh_cmd(m));
    endtask

    task automatic offer_start(input logic [6:0] a, input logic [5:0] s,
                               input logic [15:0] r);
        t_stim_cmd c;
        c            = fresh_cmd(MODE_START);
        c.addr       = a;
        c.send_count = s;
        c.recv_count = r;
        offer_cmd(c);
    endtask

    task automatic offer_load(input logic [7:0] d);
        t_stim_cmd c;
        c      = fresh_cmd(MODE_LOAD);
        c.data = d;
        offer_cmd(c);
    endtask

    task automatic offer_event(input logic arb, input logic nak, input logic [7:0] d);
        t_stim_cmd c;
        c          = fresh_cmd(MODE_EVENT);
        c.arb_lost = arb;
        c.nak      = nak;
        c.data     = d;
        offer_cmd(c);
    endtask

    // The sender stops offering and waits until every predicted action has been seen,
    // then lets any queued commands without results run out.
    task automatic drain_results();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_ops.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The timeout register is only written with no transfer in flight.
    task automatic write_timeout(input logic [15:0] ticks);
        drain_results();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= ticks;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        timeout_limit = ticks;
        cfg_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver side and result checking
    // ------------------------------------------------------------------------

    // The receiver waits a random number of cycles before each result, and honors a
    // long hold-off whenever a test asks for one.
    initial begin : result_sink
        int gap;
        i_m_tready = 1'b0;
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 19);
            repeat (gap) begin
                @(negedge i_clk);
                i_m_tready <= 1'b0;
            end
            while (sink_hold > 0) begin
                @(negedge i_clk);
                i_m_tready <= 1'b0;
                sink_hold--;
            end
            @(negedge i_clk);
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid && i_m_tready) && sink_hold == 0);
        end
    end

    // Every output transaction is compared field by field with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_expect_op want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (pending_ops.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("Unexpected result: action %0d data %02h status %0d count %0d",
                             o_m_tuser, o_m_tdata[7:0], o_m_tdata[9:8], o_m_tdata[26:10]);
                end
            end else begin
                want = pending_ops.pop_front();
                if (o_m_tuser !== want.action || o_m_tdata[7:0] !== want.data ||
                    o_m_tdata[9:8] !== want.status || o_m_tdata[26:10] !== want.count ||
                    o_m_tlast !== want.last) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("Mismatch: expected action %0d data %02h status %0d",
                                 want.action, want.data, want.status,
                                 " count %0d last %0d", want.count, want.last);
                        $display("          got      action %0d data %02h status %0d",
                                 o_m_tuser, o_m_tdata[7:0], o_m_tdata[9:8],
                                 " count %0d last %0d", o_m_tdata[26:10], o_m_tlast);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Controller traffic and unknown kinds while idle are dropped; a start with
    // nothing to move completes at once.
    task automatic test_idle_and_empty();
        offer_event(1'b1, 1'b1, 8'hff);
        offer_event(1'b0, 1'b0, 8'h00);
        offer_mode(MODE_BUS_IDLE);
        offer_mode(MODE_TICK);
        for (int m = MODE_RSVD_LO; m <= MODE_RSVD_HI; m++) offer_mode(3'(m));
        offer_start(7'h2a, 6'd0, 16'd0);
        offer_start(7'h7f, 6'd0, 16'd0);
    endtask

    // Full write, restart and read transfer with repeated restart and stop, and
    // starts, loads and ticks arriving while busy.
    task automatic test_write_restart_read();
        offer_load(8'h00);
        offer_load(8'hff);
        offer_start(7'h7f, 6'd2, 16'd2);
        offer_start(7'h00, 6'd1, 16'd0);     // ignored, transfer in flight
        offer_load(8'h3c);                   // ignored, transfer in flight
        offer_event(1'b0, 1'b0, 8'hff);
        offer_mode(MODE_TICK);
        offer_event(1'b0, 1'b0, 8'h11);
        offer_mode(MODE_BUS_IDLE);           // not waiting for the bus yet
        offer_event(1'b0, 1'b0, 8'h22);
        offer_event(1'b0, 1'b0, 8'h33);      // restart is issued again
        offer_mode(MODE_BUS_IDLE);
        offer_event(1'b0, 1'b0, 8'h44);      // dummy read
        offer_event(1'b0, 1'b1, 8'ha5);      // NAK has no effect while reading
        offer_event(1'b0, 1'b0, 8'h00);
        offer_event(1'b0, 1'b0, 8'h55);
        offer_event(1'b0, 1'b0, 8'h66);      // stop is issued again
        offer_mode(MODE_BUS_IDLE);
    endtask

    // Read-only transfer of one byte: ACK is disabled on the dummy read and again
    // before the only byte.
    task automatic test_read_only();
        offer_start(7'h00, 6'd0, 16'd1);
        offer_event(1'b0, 1'b0, 8'h12);
        offer_event(1'b0, 1'b0, 8'hff);
        offer_mode(MODE_BUS_IDLE);
        offer_event(1'b0, 1'b0, 8'h00);
        offer_mode(MODE_BUS_IDLE);
    endtask

    // Arbitration loss, NAK and timeout aborts, with the timeout register at both
    // extremes and at zero.
    task automatic test_aborts();
        offer_load(8'h5a);
        offer_start(7'h12, 6'd1, 16'd3);
        offer_event(1'b1, 1'b0, 8'h00);
        offer_start(7'h12, 6'd1, 16'd3);
        offer_event(1'b0, 1'b0, 8'h00);
        offer_event(1'b1, 1'b1, 8'hff);      // loss counts the byte already written
        offer_start(7'h01, 6'd1, 16'd0);
        offer_event(1'b0, 1'b1, 8'h00);
        write_timeout(16'd1);
        offer_start(7'h40, 6'd0, 16'd2);
        offer_mode(MODE_TICK);
        write_timeout(16'd0);
        offer_start(7'h41, 6'd0, 16'd2);
        offer_event(1'b0, 1'b0, 8'h00);
        offer_mode(MODE_TICK);
        write_timeout(16'd3);
        offer_start(7'h42, 6'd1, 16'd1);
        offer_event(1'b0, 1'b0, 8'h00);
        repeat (3) offer_mode(MODE_TICK);
        write_timeout(16'hffff);
        offer_start(7'h43, 6'd0, 16'd1);
        repeat (4) offer_mode(MODE_TICK);
        offer_event(1'b1, 1'b0, 8'h00);
    endtask

    // Fills the whole send buffer, overflows it once, and starts with a send count
    // above the buffer depth so that it saturates.
    task automatic test_send_saturation();
        for (int i = 0; i <= SEND_DEPTH; i++) offer_load(8'($urandom_range(0, 255)));
        offer_start(7'h7f, 6'd63, 16'hffff);
        repeat (SEND_DEPTH) offer_event(1'b0, 1'b0, 8'($urandom_range(0, 255)));
        offer_event(1'b0, 1'b0, 8'h00);
        offer_mode(MODE_BUS_IDLE);
        offer_event(1'b0, 1'b0, 8'h00);
        offer_event(1'b0, 1'b0, 8'h9c);
        offer_event(1'b1, 1'b0, 8'h00);
    endtask

    // The receiver holds off while the sender keeps offering, so the unit fills up
    // and stalls its input; the sender then waits for every result.
    task automatic test_backpressure();
        no_gaps   = 1'b1;
        sink_hold = HOLD_CYCLES;
        repeat (12) offer_start(7'($urandom_range(0, 127)), 6'd0, 16'd0);
        no_gaps = 1'b0;
        drain_results();
    endtask

    // One transfer with random content: a few loads, a start, and then mostly the
    // controller traffic the current phase asks for, mixed with ticks, aborts and
    // stray commands. A transfer that runs too long is ended by arbitration loss.
    task automatic random_transfer();
        t_stim_cmd c;
        int        n_load;
        int        sends;
        int        budget;
        int        steps;
        int        pick;
        bit        waiting;
        n_load = ($urandom_range(0, 19) == 0) ? SEND_DEPTH + 2 : $urandom_range(0, 3);
        repeat (n_load) offer_load(8'($urandom_range(0, 255)));
        c = fresh_cmd(MODE_START);
        case ($urandom_range(0, 19))
            0:       c.send_count = 6'($urandom_range(SEND_DEPTH + 1, 63));
            1:       c.send_count = 6'($urandom_range(5, SEND_DEPTH));
            default: c.send_count = 6'($urandom_range(0, 4));
        endcase
        if ($urandom_range(0, 3) != 0) c.recv_count = 16'($urandom_range(0, 4));
        // Never let a transfer send a buffer entry that has not been loaded.
        sends = (c.send_count > SEND_DEPTH) ? SEND_DEPTH : c.send_count;
        if (sends > tx_loaded) begin
            c.send_count = 6'(tx_loaded);
            sends        = tx_loaded;
        end
        budget = 2 * (sends + c.recv_count) + 8;
        if (budget > 80) budget = 80;
        offer_cmd(c);
        steps = 0;
        while (seq_phase != PH_IDLE) begin
            pick = $urandom_range(0, 99);
            if (steps >= budget) begin
                c          = fresh_cmd(MODE_EVENT);
                c.arb_lost = 1'b1;
            end else if (pick < 12) begin
                c = fresh_cmd(MODE_TICK);
            end else if (pick < 18) begin
                case ($urandom_range(0, 3))
                    0:       c = fresh_cmd(MODE_START);
                    1:       c = fresh_cmd(MODE_LOAD);
                    2:       c = fresh_cmd(MODE_BUS_IDLE);
                    default: c = fresh_cmd(3'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI)));
                endcase
            end else begin
                waiting = (seq_phase == PH_WAIT_RESTART) || (seq_phase == PH_WAIT_STOP);
                if (waiting && pick < 85) begin
                    c = fresh_cmd(MODE_BUS_IDLE);
                end else begin
                    c          = fresh_cmd(MODE_EVENT);
                    c.arb_lost = (pick >= 97);
                    c.nak      = (pick >= 93 && pick < 97);
                end
            end
            offer_cmd(c);
            steps++;
        end
    endtask

    task automatic random_chunk(input int n);
        int target;
        target = items_live + n;
        while (items_live < target) random_transfer();
    endtask

    // Random traffic under three timeout settings; the middle part runs with no
    // idling on either side.
    task automatic test_random_traffic();
        write_timeout(16'hffff);
        random_chunk(CHUNK_ITEMS);
        write_timeout(16'($urandom_range(2, 6)));
        no_gaps = 1'b1;
        random_chunk(CHUNK_ITEMS);
        no_gaps = 1'b0;
        write_timeout(TIMEOUT_RESET);
        random_chunk(CHUNK_ITEMS);
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------------

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 16'd0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = 40'd0;
        i_s_tuser   = MODE_START;

        seq_phase     = PH_IDLE;
        tx_fill       = 0;
        tx_next       = 0;
        tx_left       = 0;
        tx_loaded     = 0;
        rx_left       = 16'd0;
        addr_byte     = 8'h00;
        moved         = 17'd0;
        stall_ticks   = 16'd0;
        timeout_limit = TIMEOUT_RESET;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_and_empty();
        test_write_restart_read();
        test_read_only();
        test_aborts();
        test_send_saturation();
        test_backpressure();
        test_random_traffic();
        drain_results();

        errors += pending_ops.size();
        $display("Covered %0d command transactions (%0d acted on) and %0d result transactions,",
                 items_sent, items_live, results_seen);
        $display("with aborts, restarts, send saturation and %0d timeout register writes.",
                 cfg_writes);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5000000;
        $display("Watchdog expired with %0d results still expected.", pending_ops.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
